// ===== sv/lzwe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package lzwe_pkg;

    localparam int DICT_ENTRIES_DEF = 4096;
    localparam int STRING_SLOTS_DEF = 32;
    localparam int CODE_OUT_W = 12;
    localparam logic [CODE_OUT_W-1:0] PAD_CODE = 12'hFFF;
    localparam int ROOT_COUNT = 256;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECIDE,
        ST_PROBE,
        ST_CMP
    } state_t;

    typedef struct packed {
        logic clr_start;
        logic clr_step;
        logic load_in;
        logic start_str;
        logic emit;
        logic emit_end;
        logic probe_init;
        logic probe_next;
        logic hit;
        logic learn;
    } cmd_t;

    typedef struct packed {
        logic kind;
        logic len_zero;
        logic len_max;
        logic pend_valid;
        logic ob_free;
        logic rd_empty;
        logic rd_match;
        logic clr_done;
    } status_t;

endpackage
`default_nettype wire

// ===== sv/lzwe_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lzwe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8192
) (
    input  wire                     clk,
    input  wire                     we,
    input  wire [$clog2(DEPTH)-1:0] waddr,
    input  wire [WIDTH-1:0]         wdata,
    input  wire [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== sv/lzwe_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lzwe_ctrl (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              in_valid,
    output logic             in_ready,
    input  lzwe_pkg::status_t st,
    output lzwe_pkg::cmd_t    cmd
);

    lzwe_pkg::state_t state_reg;
    lzwe_pkg::state_t state_next;
    logic emit_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lzwe_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        emit_ok = !st.pend_valid || st.ob_free;
        case (state_reg)
            lzwe_pkg::ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (st.clr_done)
                begin
                    state_next = lzwe_pkg::ST_IDLE;
                end
            end
            lzwe_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next = lzwe_pkg::ST_DECIDE;
                end
            end
            lzwe_pkg::ST_DECIDE:
            begin
                if (st.kind)
                begin
                    if (st.len_zero)
                    begin
                        cmd.clr_start = 1'b1;
                        state_next = lzwe_pkg::ST_CLEAR;
                    end
                    else if (st.ob_free)
                    begin
                        cmd.emit = 1'b1;
                        cmd.emit_end = 1'b1;
                        cmd.clr_start = 1'b1;
                        state_next = lzwe_pkg::ST_CLEAR;
                    end
                end
                else if (st.len_zero)
                begin
                    cmd.start_str = 1'b1;
                    state_next = lzwe_pkg::ST_IDLE;
                end
                else if (st.len_max)
                begin
                    if (emit_ok)
                    begin
                        cmd.emit = 1'b1;
                        cmd.start_str = 1'b1;
                        state_next = lzwe_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    cmd.probe_init = 1'b1;
                    state_next = lzwe_pkg::ST_PROBE;
                end
            end
            lzwe_pkg::ST_PROBE:
            begin
                state_next = lzwe_pkg::ST_CMP;
            end
            lzwe_pkg::ST_CMP:
            begin
                if (st.rd_match)
                begin
                    cmd.hit = 1'b1;
                    state_next = lzwe_pkg::ST_IDLE;
                end
                else if (st.rd_empty)
                begin
                    if (emit_ok)
                    begin
                        cmd.emit = 1'b1;
                        cmd.learn = 1'b1;
                        cmd.start_str = 1'b1;
                        state_next = lzwe_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    cmd.probe_next = 1'b1;
                    state_next = lzwe_pkg::ST_PROBE;
                end
            end
            default:
            begin
                state_next = lzwe_pkg::ST_CLEAR;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== sv/lzwe_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lzwe_dp #(
    parameter int DICT_ENTRIES = lzwe_pkg::DICT_ENTRIES_DEF,
    parameter int STRING_SLOTS = lzwe_pkg::STRING_SLOTS_DEF
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               in_kind,
    input  wire [7:0]         in_byte,
    output logic [7:0]        out_byte,
    output logic              out_last,
    output logic              out_valid,
    input  wire               out_ready,
    input  lzwe_pkg::cmd_t    cmd,
    output lzwe_pkg::status_t st
);

    localparam int CW = $clog2(DICT_ENTRIES);
    localparam int HW = CW + 1;
    localparam int HASH_DEPTH = 1 << HW;
    localparam int LW = $clog2(STRING_SLOTS);
    localparam int EW = 2 * CW + 8;
    localparam int OW = lzwe_pkg::CODE_OUT_W;

    logic          kind_reg;
    logic [7:0]    k_reg;
    logic [CW-1:0] cur_reg;
    logic [LW-1:0] len_reg;
    logic [CW-1:0] free_reg;
    logic [OW-1:0] pend_reg;
    logic          pend_valid_reg;
    logic [HW-1:0] addr_reg;
    logic [HW-1:0] clr_reg;
    logic [2*OW-1:0] ob_reg;
    logic [1:0]    ob_cnt_reg;
    logic          ob_last_reg;

    logic [HW-1:0] hash;
    logic [EW-1:0] rdata;
    logic [EW-1:0] wdata;
    logic [HW-1:0] waddr;
    logic          we;
    logic [CW-1:0] rd_code;
    logic [CW-1:0] rd_prefix;
    logic [7:0]    rd_byte;
    logic [OW-1:0] cur_out;
    logic          full;

    assign hash = HW'(cur_reg) ^ (HW'(k_reg) << (HW - 8));
    assign {rd_code, rd_prefix, rd_byte} = rdata;
    assign cur_out = OW'(cur_reg);
    assign full = free_reg >= CW'(DICT_ENTRIES - 1);

    assign we = cmd.clr_step || (cmd.learn && !full);
    assign waddr = cmd.clr_step ? clr_reg : addr_reg;
    assign wdata = cmd.clr_step ? '0 : {free_reg, cur_reg, k_reg};

    lzwe_ram #(
        .WIDTH(EW),
        .DEPTH(HASH_DEPTH)
    ) u_hash_ram (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(addr_reg),
        .rdata(rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            kind_reg <= in_kind;
            k_reg <= in_byte;
        end
        if (cmd.probe_init)
        begin
            addr_reg <= hash;
        end
        else if (cmd.probe_next)
        begin
            addr_reg <= addr_reg + HW'(1);
        end
        if (cmd.hit)
        begin
            cur_reg <= rd_code;
        end
        else if (cmd.start_str)
        begin
            cur_reg <= CW'(k_reg);
        end
        if (cmd.emit && (pend_valid_reg || cmd.emit_end))
        begin
            ob_reg <= pend_valid_reg ? {pend_reg, cur_out} : {cur_out, lzwe_pkg::PAD_CODE};
            ob_last_reg <= cmd.emit_end;
        end
        if (cmd.emit && !pend_valid_reg)
        begin
            pend_reg <= cur_out;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
            free_reg <= CW'(lzwe_pkg::ROOT_COUNT);
            pend_valid_reg <= 1'b0;
            clr_reg <= '0;
            ob_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.clr_start)
            begin
                len_reg <= '0;
                free_reg <= CW'(lzwe_pkg::ROOT_COUNT);
                pend_valid_reg <= 1'b0;
                clr_reg <= '0;
            end
            else
            begin
                if (cmd.hit)
                begin
                    len_reg <= len_reg + LW'(1);
                end
                else if (cmd.start_str)
                begin
                    len_reg <= LW'(1);
                end
                if (cmd.learn && !full)
                begin
                    free_reg <= free_reg + CW'(1);
                end
                if (cmd.emit)
                begin
                    pend_valid_reg <= !pend_valid_reg;
                end
                if (cmd.clr_step)
                begin
                    clr_reg <= clr_reg + HW'(1);
                end
            end
            if (cmd.emit && (pend_valid_reg || cmd.emit_end))
            begin
                ob_cnt_reg <= 2'd3;
            end
            else if (out_valid && out_ready)
            begin
                ob_cnt_reg <= ob_cnt_reg - 2'd1;
            end
        end
    end

    always_comb
    begin
        case (ob_cnt_reg)
            2'd3:    out_byte = ob_reg[23:16];
            2'd2:    out_byte = ob_reg[15:8];
            default: out_byte = ob_reg[7:0];
        endcase
    end

    assign out_valid = ob_cnt_reg != 2'd0;
    assign out_last = ob_last_reg && (ob_cnt_reg == 2'd1);

    assign st.kind = kind_reg;
    assign st.len_zero = len_reg == '0;
    assign st.len_max = len_reg >= LW'(STRING_SLOTS - 1);
    assign st.pend_valid = pend_valid_reg;
    assign st.ob_free = ob_cnt_reg == 2'd0;
    assign st.rd_empty = rd_code == '0;
    assign st.rd_match = (rd_code != '0) && (rd_prefix == cur_reg) && (rd_byte == k_reg);
    assign st.clr_done = clr_reg == HW'(HASH_DEPTH - 1);

    a_emit_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit && (pend_valid_reg || cmd.emit_end) |-> ob_cnt_reg == 2'd0)
        else $error("output buffer overwritten");
    a_learn_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.learn |-> rd_code == '0)
        else $error("insert into occupied slot");
    a_hit_len: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.hit |=> len_reg <= LW'(STRING_SLOTS - 1))
        else $error("string length overflow");

endmodule
`default_nettype wire

// ===== sv/lzw_encoder_12bit_packed_top.sv =====
// LZW encoder with fixed 12-bit codes, packed two codes into three bytes.
// The slave stream takes one transaction per raw byte: tdata holds the byte
// and tuser is 0, or tuser is 1 to mark the end of the stream.
// The master stream delivers packed bytes, big-endian, with tlast on the
// final byte of the whole compressed stream.
// A data byte needs no lookup when it starts a string or when the current
// string is at its maximum length; otherwise the hashed dictionary is
// probed entry by entry through the registered read port of the dictionary
// memory until a match or an empty slot is found. Three output bytes follow
// a transaction that completes a pair of codes, starting in the cycle after
// that transaction is decided. After reset and after every end marker, the
// dictionary memory of 2*2^clog2(DICT_ENTRIES) entries (8192 at the default
// size) is cleared one entry per cycle; tready stays low during that time.
// When the receiver stalls, the three pending bytes are held; the block
// keeps taking input until another code pair must be written.
`timescale 1ns / 1ps
`default_nettype none
module lzw_encoder_12bit_packed_top #(
    parameter int DICT_ENTRIES = lzwe_pkg::DICT_ENTRIES_DEF,
    parameter int STRING_SLOTS = lzwe_pkg::STRING_SLOTS_DEF
) (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        s_axis_tvalid,
    output logic       s_axis_tready,
    input  wire [7:0]  s_axis_tdata,  // data_byte
    input  wire        s_axis_tuser,  // kind
    output logic       m_axis_tvalid,
    input  wire        m_axis_tready,
    output logic [7:0] m_axis_tdata,  // out_byte
    output logic       m_axis_tlast
);

    lzwe_pkg::cmd_t    cmd;
    lzwe_pkg::status_t st;

    lzwe_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(s_axis_tvalid),
        .in_ready(s_axis_tready),
        .st      (st),
        .cmd     (cmd)
    );

    lzwe_dp #(
        .DICT_ENTRIES(DICT_ENTRIES),
        .STRING_SLOTS(STRING_SLOTS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_kind  (s_axis_tuser),
        .in_byte  (s_axis_tdata),
        .out_byte (m_axis_tdata),
        .out_last (m_axis_tlast),
        .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready),
        .cmd      (cmd),
        .st       (st)
    );

endmodule
`default_nettype wire

// ===== dv/lzw_encoder_12bit_packed_top_tb.sv =====
`timescale 1ns / 1ps
module lzw_encoder_12bit_packed_top_tb;

    localparam int DICT_SIZE = lzwe_pkg::DICT_ENTRIES_DEF;
    localparam int MAX_STR_LEN = lzwe_pkg::STRING_SLOTS_DEF - 1;
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END = 1'b1;
    localparam int IDLE_LIMIT = 30000;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } packed_byte_t;

    class lzw_scoreboard;
        logic [11:0]  prefix_of [DICT_SIZE];
        logic [7:0]   byte_of [DICT_SIZE];
        logic [11:0]  cur_code;
        int           cur_len;
        int           next_free;
        logic [11:0]  held_code;
        bit           held_valid;
        packed_byte_t packed_q[$];
        int           errors;

        function void restart();
            cur_code = '0;
            cur_len = 0;
            next_free = lzwe_pkg::ROOT_COUNT;
            held_code = '0;
            held_valid = 0;
        endfunction

        function void emit_code(logic [11:0] code, bit is_end);
            packed_byte_t b;
            if (!held_valid)
            begin
                held_code = code;
                held_valid = 1;
                return;
            end
            b.out_byte = held_code[11:4];
            b.last = 1'b0;
            packed_q.push_back(b);
            b.out_byte = {held_code[3:0], code[11:8]};
            packed_q.push_back(b);
            b.out_byte = code[7:0];
            b.last = is_end;
            packed_q.push_back(b);
            held_valid = 0;
            held_code = '0;
        endfunction

        function int lookup(logic [11:0] pfx, logic [7:0] k);
            for (int c = lzwe_pkg::ROOT_COUNT; c < next_free; c++)
            begin
                if (prefix_of[c] == pfx && byte_of[c] == k)
                    return c;
            end
            return -1;
        endfunction

        function void note_input(logic kind, logic [7:0] k);
            int hit;
            if (kind == KIND_END)
            begin
                if (cur_len != 0)
                begin
                    emit_code(cur_code, 1);
                    if (held_valid)
                        emit_code(lzwe_pkg::PAD_CODE, 1);
                end
                restart();
                return;
            end
            if (cur_len >= MAX_STR_LEN)
            begin
                emit_code(cur_code, 0);
                cur_len = 0;
            end
            if (cur_len == 0)
            begin
                cur_code = {4'h0, k};
                cur_len = 1;
                return;
            end
            hit = lookup(cur_code, k);
            if (hit >= 0)
            begin
                cur_code = hit[11:0];
                cur_len++;
                return;
            end
            emit_code(cur_code, 0);
            if (next_free < DICT_SIZE - 1)
            begin
                prefix_of[next_free] = cur_code;
                byte_of[next_free] = k;
                next_free++;
            end
            cur_code = {4'h0, k};
            cur_len = 1;
        endfunction

        function void check(logic [7:0] got_byte, logic got_last);
            packed_byte_t e;
            if (packed_q.size() == 0)
            begin
                $display("%0t: unexpected output byte, expected none, actual %02h last %0b",
                         $realtime, got_byte, got_last);
                errors++;
                return;
            end
            e = packed_q.pop_front();
            if (e.out_byte !== got_byte)
            begin
                $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                         $realtime, e.out_byte, got_byte);
                errors++;
            end
            if (e.last !== got_last)
            begin
                $display("%0t: last mismatch, expected %0b, actual %0b",
                         $realtime, e.last, got_last);
                errors++;
            end
        endfunction
    endclass

    logic       clk = 0;
    logic       rst_n = 0;
    logic       s_axis_tvalid = 0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = '0;
    logic       s_axis_tuser = 0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 0;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tlast;

    lzw_scoreboard encoder_sb;
    int burst_left = 0;
    int idle_cycles = 0;
    int ready_cycle = 0;
    int ready_mode = 0;

    lzw_encoder_12bit_packed_top i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast)
    );

    always #2 clk = ~clk;

    task automatic send_item(logic kind, logic [7:0] k);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= kind;
        s_axis_tdata <= k;
        do
            @(posedge clk);
        while (!(s_axis_tvalid && s_axis_tready));
        encoder_sb.note_input(kind, k);
        burst_left--;
    endtask

    task automatic send_stream(int len, int base, int span);
        for (int i = 0; i < len; i++)
            send_item(KIND_DATA, 8'((base + $urandom_range(0, span)) % 256));
        send_item(KIND_END, 8'($urandom));
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                encoder_sb.check(m_axis_tdata, m_axis_tlast);
            ready_cycle++;
            if (ready_cycle % 64 == 0)
                ready_mode = $urandom_range(0, 2);
            case (ready_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 1) == 1);
                default: m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("lzw_encoder_12bit_packed_top regression: fail");
            $finish;
        end
    end

    initial
    begin
        encoder_sb = new();
        encoder_sb.restart();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // An end marker on an empty stream produces nothing.
        send_item(KIND_END, 8'hFF);
        // A single code is padded with the filler code.
        send_item(KIND_DATA, 8'h00);
        send_item(KIND_END, 8'h00);
        // Two codes fill one pair exactly.
        send_item(KIND_DATA, 8'hFF);
        send_item(KIND_DATA, 8'h80);
        send_item(KIND_END, 8'h5A);
        // Repeats learn strings and then hit them.
        for (int i = 0; i < 10; i++)
            send_item(KIND_DATA, 8'h41);
        send_item(KIND_DATA, 8'h01);
        send_item(KIND_DATA, 8'hFE);
        send_item(KIND_END, 8'hA5);

        // A long run of one byte grows ever longer strings.
        send_stream(110, 8'h00, 0);
        // Random bytes mostly learn fresh pairs.
        send_stream(100, 0, 255);

        for (int s = 0; s < 4; s++)
        begin
            if ($urandom_range(0, 3) == 0)
                send_stream($urandom_range(1, 12), 0, 255);
            else
                send_stream($urandom_range(1, 12), $urandom_range(0, 255), 3);
        end

        while (encoder_sb.packed_q.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (encoder_sb.errors == 0)
            $display("lzw_encoder_12bit_packed_top regression: pass");
        else
            $display("lzw_encoder_12bit_packed_top regression: fail");
        $finish;
    end

endmodule
